[design/pim_pkg.sv]
// ----------------------------------------------------------------------------
// pim_pkg
// Shared types and constants for the priority-inheritance mutex.
// ----------------------------------------------------------------------------
package pim_pkg;

  localparam int unsigned MaxWaitersDef = 16;
  localparam int unsigned PrioBitsDef   = 8;
  localparam int unsigned TaskIdBitsDef = 4;

  typedef enum logic [0:0] {
    ACT_LOCK   = 1'b0,
    ACT_UNLOCK = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic step;
    logic first;
  } pim_scan_ctrl_t;

endpackage

[design/pim_if.sv]
// ----------------------------------------------------------------------------
// pim_req_if / pim_rsp_if
// Valid/ready channels carrying mutex requests and their results.
// ----------------------------------------------------------------------------
interface pim_req_if import pim_pkg::*; #(
  parameter int unsigned TidW  = TaskIdBitsDef,
  parameter int unsigned PrioW = PrioBitsDef
);
  logic             valid;
  logic             ready;
  action_e          action;
  logic [TidW-1:0]  task_id;
  logic [PrioW-1:0] bprio;
  logic [PrioW-1:0] cprio;

  modport source (output valid, action, task_id, bprio, cprio, input ready);
  modport sink   (input valid, action, task_id, bprio, cprio, output ready);
endinterface

interface pim_rsp_if import pim_pkg::*; #(
  parameter int unsigned TidW  = TaskIdBitsDef,
  parameter int unsigned PrioW = PrioBitsDef
);
  logic             valid;
  logic             ready;
  status_e          status;
  logic             prio_change_valid;
  logic [TidW-1:0]  prio_change_task;
  logic [PrioW-1:0] prio_change_value;
  logic             wake_valid;
  logic [TidW-1:0]  wake_task;

  modport source (output valid, status, prio_change_valid, prio_change_task,
                  prio_change_value, wake_valid, wake_task, input ready);
  modport sink   (input valid, status, prio_change_valid, prio_change_task,
                  prio_change_value, wake_valid, wake_task, output ready);
endinterface

[design/pim_scan_unit.sv]
// ----------------------------------------------------------------------------
// pim_scan_unit
// Shared comparator tracking the highest-priority waiter during a scan.
// ----------------------------------------------------------------------------
module pim_scan_unit import pim_pkg::*; #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned TidW  = TaskIdBitsDef,
  parameter int unsigned PrioW = PrioBitsDef
) (
  input  logic             clk_i,
  input  pim_scan_ctrl_t   ctrl_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [TidW-1:0]  id_i,
  input  logic [PrioW-1:0] prio_i,
  output logic [IdxW-1:0]  best_idx_o,
  output logic [TidW-1:0]  best_id_o
);

  logic [IdxW-1:0]  best_idx_q;
  logic [TidW-1:0]  best_id_q;
  logic [PrioW-1:0] best_prio_q;
  logic             take;

  // strict compare: scanning newest to oldest keeps the newest on ties
  assign take = ctrl_i.step && (ctrl_i.first || (prio_i > best_prio_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= idx_i;
      best_id_q   <= id_i;
      best_prio_q <= prio_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_id_o  = best_id_q;

endmodule

[design/priority_inheritance_mutex_top.sv]
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_top
// Single mutex with priority inheritance and a waiter list scanned newest first.
// ----------------------------------------------------------------------------
// One request at a time. A lock, or an ignored unlock, passes only the execute
// and done states after accept. An unlock with waiters also scans every waiter
// and then moves each entry above the woken waiter's slot down one place,
// because the waiter list sits in a single-port-read memory: one entry is read
// per cycle for the priority scan through one comparator, then one per cycle
// for list compaction. The result beat is held in an output register, so a new
// request is taken while it waits.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex_top import pim_pkg::*; #(
  parameter int unsigned MAX_WAITERS  = MaxWaitersDef,
  parameter int unsigned PRIO_BITS    = PrioBitsDef,
  parameter int unsigned TASK_ID_BITS = TaskIdBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pim_req_if.sink    in_i,
  pim_rsp_if.source  out_o
);

  localparam int unsigned IW = $clog2(MAX_WAITERS);
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned TW = TASK_ID_BITS;
  localparam int unsigned PW = PRIO_BITS;
  localparam int unsigned EW = TW + PW;

  // waiter list, slot 0 oldest
  logic [EW-1:0] mem_q [MAX_WAITERS];
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          ren;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata_q;

  state_e        state_q, state_d;
  logic          held_q, held_d;
  logic [TW-1:0] owner_id_q, owner_id_d;
  logic [PW-1:0] owner_prio_q, owner_prio_d;
  logic          boost_q, boost_d;
  logic [PW-1:0] saved_q, saved_d;
  logic [CW-1:0] count_q, count_d;

  action_e       act_q;
  logic [TW-1:0] tid_q;
  logic [PW-1:0] bprio_q, cprio_q;

  status_e       res_status_q, res_status_d;
  logic          res_pcv_q, res_pcv_d;
  logic [TW-1:0] res_pct_q, res_pct_d;
  logic [PW-1:0] res_pcval_q, res_pcval_d;
  logic          res_wv_q, res_wv_d;
  logic [TW-1:0] res_wt_q, res_wt_d;

  logic [IW-1:0] scan_q, scan_d;
  logic          first_q, first_d;
  logic [IW-1:0] sh_q, sh_d;

  logic          out_valid_q;
  logic          out_load;
  status_e       out_status_q;
  logic          out_pcv_q;
  logic [TW-1:0] out_pct_q;
  logic [PW-1:0] out_pcval_q;
  logic          out_wv_q;
  logic [TW-1:0] out_wt_q;

  pim_scan_ctrl_t scan_ctrl;
  logic [IW-1:0]  best_idx;
  logic [TW-1:0]  best_id;

  logic [CW-1:0] cnt_m1;
  logic [IW:0]   best_p1;
  logic [IW:0]   sh_p2;

  pim_scan_unit #(
    .IdxW  (IW),
    .TidW  (TW),
    .PrioW (PW)
  ) u_scan (
    .clk_i      (clk_i),
    .ctrl_i     (scan_ctrl),
    .idx_i      (scan_q),
    .id_i       (rdata_q[EW-1:PW]),
    .prio_i     (rdata_q[PW-1:0]),
    .best_idx_o (best_idx),
    .best_id_o  (best_id)
  );

  assign in_i.ready = (state_q == S_IDLE);

  assign cnt_m1  = count_q - CW'(1);
  assign best_p1 = {1'b0, best_idx} + (IW+1)'(1);
  assign sh_p2   = {1'b0, sh_q} + (IW+1)'(2);

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    owner_id_d   = owner_id_q;
    owner_prio_d = owner_prio_q;
    boost_d      = boost_q;
    saved_d      = saved_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_pcv_d    = res_pcv_q;
    res_pct_d    = res_pct_q;
    res_pcval_d  = res_pcval_q;
    res_wv_d     = res_wv_q;
    res_wt_d     = res_wt_q;
    scan_d       = scan_q;
    first_d      = first_q;
    sh_d         = sh_q;
    we           = 1'b0;
    waddr        = count_q[IW-1:0];
    wdata        = {tid_q, bprio_q};
    ren          = 1'b0;
    raddr        = cnt_m1[IW-1:0];
    scan_ctrl    = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_pcv_d   = 1'b0;
        res_pct_d   = '0;
        res_pcval_d = '0;
        res_wv_d    = 1'b0;
        res_wt_d    = '0;
        state_d     = S_DONE;
        if (act_q == ACT_LOCK) begin
          if (!held_q) begin
            held_d       = 1'b1;
            owner_id_d   = tid_q;
            owner_prio_d = cprio_q;
            res_status_d = ST_GRANTED;
          end else begin
            if (bprio_q > owner_prio_q) begin
              if (!boost_q) begin
                saved_d = owner_prio_q;
                boost_d = 1'b1;
              end
              owner_prio_d = bprio_q;
              res_pcv_d    = 1'b1;
              res_pct_d    = owner_id_q;
              res_pcval_d  = bprio_q;
            end
            if (count_q == CW'(MAX_WAITERS)) begin
              res_status_d = ST_FULL;
            end else begin
              we           = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = ST_BLOCKED;
            end
          end
        end else begin
          if (!held_q || (tid_q != owner_id_q)) begin
            res_status_d = ST_IGNORED;
          end else begin
            if (boost_q) begin
              res_pcv_d    = 1'b1;
              res_pct_d    = owner_id_q;
              res_pcval_d  = saved_q;
              owner_prio_d = saved_q;
              boost_d      = 1'b0;
            end
            held_d       = 1'b0;
            res_status_d = ST_RELEASED;
            if (count_q != '0) begin
              ren     = 1'b1;
              scan_d  = cnt_m1[IW-1:0];
              first_d = 1'b1;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        scan_ctrl.step  = 1'b1;
        scan_ctrl.first = first_q;
        first_d         = 1'b0;
        if (scan_q == '0) begin
          state_d = S_PICK;
        end else begin
          ren     = 1'b1;
          raddr   = scan_q - IW'(1);
          scan_d  = scan_q - IW'(1);
        end
      end
      S_PICK: begin
        count_d  = cnt_m1;
        res_wv_d = 1'b1;
        res_wt_d = best_id;
        if (CW'(best_idx) < cnt_m1) begin
          ren     = 1'b1;
          raddr   = best_p1[IW-1:0];
          sh_d    = best_idx;
          state_d = S_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        // count already reduced: slot sh takes slot sh+1
        we    = 1'b1;
        waddr = sh_q;
        wdata = rdata_q;
        if ((CW'(sh_q) + CW'(1)) < count_q) begin
          ren     = 1'b1;
          raddr   = sh_p2[IW-1:0];
          sh_d    = sh_q + IW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      held_q       <= 1'b0;
      owner_id_q   <= '0;
      owner_prio_q <= '0;
      boost_q      <= 1'b0;
      saved_q      <= '0;
      count_q      <= '0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      owner_id_q   <= owner_id_d;
      owner_prio_q <= owner_prio_d;
      boost_q      <= boost_d;
      saved_q      <= saved_d;
      count_q      <= count_d;
      first_q      <= first_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q   <= in_i.action;
      tid_q   <= in_i.task_id;
      bprio_q <= in_i.bprio;
      cprio_q <= in_i.cprio;
    end
    res_status_q <= res_status_d;
    res_pcv_q    <= res_pcv_d;
    res_pct_q    <= res_pct_d;
    res_pcval_q  <= res_pcval_d;
    res_wv_q     <= res_wv_d;
    res_wt_q     <= res_wt_d;
    scan_q       <= scan_d;
    sh_q         <= sh_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pcv_q    <= res_pcv_q;
      out_pct_q    <= res_pct_q;
      out_pcval_q  <= res_pcval_q;
      out_wv_q     <= res_wv_q;
      out_wt_q     <= res_wt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = out_status_q;
  assign out_o.prio_change_valid = out_pcv_q;
  assign out_o.prio_change_task  = out_pct_q;
  assign out_o.prio_change_value = out_pcval_q;
  assign out_o.wake_valid        = out_wv_q;
  assign out_o.wake_task         = out_wt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WAITERS))
    else $error("waiter count beyond list depth");

  a_boost_needs_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boost_q |-> held_q)
    else $error("boost active on a free mutex");

  a_pick_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (count_q != '0) && !held_q)
    else $error("waiter pick with empty list or held mutex");

  a_wake_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.wake_valid |-> out_o.status == ST_RELEASED)
    else $error("wake reported on a beat that is not a release");

endmodule

[dv/priority_inheritance_mutex_top_tb.sv]
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_top_tb
// Self-checking bench for the priority-inheritance mutex. A predictor in the
// bench tracks owner, boost and waiter list, and works out the result of each
// accepted request. Directed cases come first, then random lock/unlock
// traffic. Both channels stall at random, and one long sink hold-off fills
// the block so that it back-pressures.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex_top_tb import pim_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TidW       = TaskIdBitsDef;
  localparam int PrioW      = PrioBitsDef;
  localparam int Depth      = MaxWaitersDef;
  localparam int CycleLimit = 1_000_000;

  typedef struct packed {
    action_e          action;
    logic [TidW-1:0]  task_id;
    logic [PrioW-1:0] bprio;
    logic [PrioW-1:0] cprio;
  } mutex_req_t;

  typedef struct packed {
    status_e          status;
    logic             pcv;
    logic [TidW-1:0]  pct;
    logic [PrioW-1:0] pcval;
    logic             wv;
    logic [TidW-1:0]  wt;
  } mutex_rsp_t;

  logic clk_i;
  logic rst_ni;

  pim_req_if #(.TidW(TidW), .PrioW(PrioW)) req_if ();
  pim_rsp_if #(.TidW(TidW), .PrioW(PrioW)) rsp_if ();

  priority_inheritance_mutex_top #(
    .MAX_WAITERS (Depth),
    .PRIO_BITS   (PrioW),
    .TASK_ID_BITS(TidW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // predicted mutex state
  bit               held;
  bit               boosted;
  logic [TidW-1:0]  owner_id;
  logic [PrioW-1:0] owner_prio;
  logic [PrioW-1:0] saved_prio;
  int               n_waiting;
  logic [TidW-1:0]  wait_tid [Depth];
  logic [PrioW-1:0] wait_prio[Depth];

  mutex_rsp_t outcomes_due[$];

  bit               has_woken;
  logic [TidW-1:0]  last_woken;
  bit               src_idle_on;
  bit               sink_idle_on;
  int               sink_hold_cycles;
  int               mismatches;
  int               cycle_count;
  int               n_effective;
  int               status_seen[5];
  int               n_wakes;
  int               n_prio_changes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  function automatic mutex_rsp_t mutex_outcome(input mutex_req_t r);
    mutex_rsp_t o;
    int         best;
    int         i;
    o = '0;
    if (r.action == ACT_LOCK) begin
      if (!held) begin
        held       = 1'b1;
        owner_id   = r.task_id;
        owner_prio = r.cprio;
        o.status   = ST_GRANTED;
      end else begin
        if (r.bprio > owner_prio) begin
          if (!boosted) begin
            saved_prio = owner_prio;
            boosted    = 1'b1;
          end
          owner_prio = r.bprio;
          o.pcv      = 1'b1;
          o.pct      = owner_id;
          o.pcval    = r.bprio;
        end
        if (n_waiting >= Depth) begin
          o.status = ST_FULL;
        end else begin
          wait_tid[n_waiting]  = r.task_id;
          wait_prio[n_waiting] = r.bprio;
          n_waiting++;
          o.status = ST_BLOCKED;
        end
      end
    end else if (!held || r.task_id != owner_id) begin
      o.status = ST_IGNORED;
    end else begin
      o.status = ST_RELEASED;
      if (boosted) begin
        o.pcv      = 1'b1;
        o.pct      = owner_id;
        o.pcval    = saved_prio;
        owner_prio = saved_prio;
        boosted    = 1'b0;
      end
      held = 1'b0;
      if (n_waiting > 0) begin
        // newest first, strict compare: ties go to the newest waiter
        best = n_waiting - 1;
        for (i = n_waiting - 2; i >= 0; i--) begin
          if (wait_prio[i] > wait_prio[best]) best = i;
        end
        o.wv = 1'b1;
        o.wt = wait_tid[best];
        for (i = best; i < n_waiting - 1; i++) begin
          wait_tid[i]  = wait_tid[i + 1];
          wait_prio[i] = wait_prio[i + 1];
        end
        n_waiting--;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    mutex_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = outcomes_due.pop_front();
        check_field("status", rsp_if.status, want.status);
        check_field("prio_change_valid", rsp_if.prio_change_valid, want.pcv);
        check_field("prio_change_task", rsp_if.prio_change_task, want.pct);
        check_field("prio_change_value", rsp_if.prio_change_value, want.pcval);
        check_field("wake_valid", rsp_if.wake_valid, want.wv);
        check_field("wake_task", rsp_if.wake_task, want.wt);
      end
    end
  end

  // sink side: random stalls, plus the long hold-off when asked for
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_cycles != 0) begin
        stall_left       = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input mutex_req_t r);
    mutex_rsp_t o;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= r.action;
    req_if.task_id <= r.task_id;
    req_if.bprio   <= r.bprio;
    req_if.cprio   <= r.cprio;
    do @(posedge clk_i); while (!req_if.ready);
    o = mutex_outcome(r);
    outcomes_due.push_back(o);
    status_seen[o.status]++;
    if (o.status != ST_IGNORED) n_effective++;
    if (o.pcv) n_prio_changes++;
    if (o.wv) begin
      n_wakes++;
      last_woken = o.wt;
      has_woken  = 1'b1;
    end
  endtask

  task automatic req_lock(input int tid, input int bprio, input int cprio);
    send_request('{ACT_LOCK, TidW'(tid), PrioW'(bprio), PrioW'(cprio)});
  endtask

  task automatic req_unlock(input int tid);
    send_request('{ACT_UNLOCK, TidW'(tid), PrioW'($urandom()), PrioW'($urandom())});
  endtask

  function automatic logic [PrioW-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0:       return PrioW'($urandom_range(0, 3) * 85);
      1:       return PrioW'(int'(owner_prio) + $urandom_range(0, 2) - 1);
      default: return PrioW'($urandom_range(0, (1 << PrioW) - 1));
    endcase
  endfunction

  function automatic mutex_req_t pick_request(input int release_pct);
    mutex_req_t r;
    int         roll;
    r.action  = ACT_LOCK;
    r.task_id = TidW'($urandom_range(0, (1 << TidW) - 1));
    r.bprio   = rand_prio();
    r.cprio   = rand_prio();
    roll      = $urandom_range(0, 99);
    if (!held) begin
      if (roll < 8) begin
        r.action = ACT_UNLOCK;
      end else if (has_woken && roll < 75) begin
        r.task_id = last_woken;
        has_woken = 1'b0;
      end
    end else if (roll < release_pct) begin
      r.action  = ACT_UNLOCK;
      r.task_id = owner_id;
    end else if (roll < release_pct + 8) begin
      r.action = ACT_UNLOCK;
    end else if (roll < release_pct + 14) begin
      r.task_id = owner_id;
    end
    return r;
  endfunction

  task automatic test_directed_cases();
    int k;
    req_unlock(0);
    req_lock(3, 10, 0);
    req_unlock(3);
    req_lock(3, 10, 0);
    req_lock(3, 20, 7);
    req_lock(5, 0, 255);
    req_unlock(5);
    for (k = 0; k < 14; k++) req_lock(k + 1, (k % 7) * 30, 255 - k);
    req_lock(15, 255, 0);
    req_unlock(3);
    req_lock(0, 255, 255);
    req_unlock(0);
  endtask

  task automatic test_backpressure();
    int k;
    src_idle_on      = 1'b0;
    sink_hold_cycles = 300;
    for (k = 0; k < 10; k++) send_request(pick_request(35));
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int target, input int release_pct,
                                     input bit idle);
    int start;
    int sent;
    start = n_effective;
    sent  = 0;
    src_idle_on  = idle;
    sink_idle_on = idle;
    while (n_effective - start < target) begin
      if (idle && sent % 50 == 0) begin
        src_idle_on  = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
      end
      send_request(pick_request(release_pct));
      sent++;
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.action  <= ACT_LOCK;
    req_if.task_id <= '0;
    req_if.bprio   <= '0;
    req_if.cprio   <= '0;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(500, 35, 1'b1);
    test_backpressure();
    test_random_traffic(400, 20, 1'b1);
    test_random_traffic(400, 50, 1'b1);
    test_random_traffic(600, 35, 1'b0);

    req_if.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d requests in %0d cycles: %0d grants, %0d blocks, %0d releases",
             n_effective + status_seen[ST_IGNORED], cycle_count, status_seen[ST_GRANTED],
             status_seen[ST_BLOCKED], status_seen[ST_RELEASED]);
    $display("  %0d ignored unlocks, %0d full-list locks, %0d wakes, %0d priority changes",
             status_seen[ST_IGNORED], status_seen[ST_FULL], n_wakes, n_prio_changes);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pim_pkg.sv
design/pim_if.sv
design/pim_scan_unit.sv
design/priority_inheritance_mutex_top.sv
dv/priority_inheritance_mutex_top_tb.sv
